>>> rtl/core/hrcl_pkg.sv
`default_nettype none

package hrcl_pkg;

  // hue scale; the hue window wraps around this many steps
  localparam int HUE_STEPS = 180;

  localparam logic [8:0] HUE_STEPS_W = 9'(HUE_STEPS);
  localparam logic [7:0] HUE_MAX     = 8'(HUE_STEPS - 1);
  localparam logic [7:0] HUE_CAP     = 8'((HUE_STEPS - 1) / 2);
  localparam logic [7:0] CNT_MAX     = 8'd255;
  localparam logic [7:0] CHAN_MAX    = 8'd255;

  // action codes; six and seven are ignored
  localparam logic [2:0] ACT_CLASSIFY = 3'd0;
  localparam logic [2:0] ACT_PICK     = 3'd1;
  localparam logic [2:0] ACT_AVERAGE  = 3'd2;
  localparam logic [2:0] ACT_INCLUDE  = 3'd3;
  localparam logic [2:0] ACT_UNDO     = 3'd4;
  localparam logic [2:0] ACT_LOAD     = 3'd5;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] pixel_hue;
    logic [7:0] pixel_sat;
    logic [7:0] pixel_val;
    logic [7:0] load_range_h;
    logic [7:0] load_range_s;
    logic [7:0] load_range_v;
  } pixel_t;

  typedef struct packed {
    logic       in_range;
    logic [7:0] cur_hue;
    logic [7:0] cur_sat;
    logic [7:0] cur_val;
    logic [7:0] cur_range_h;
    logic [7:0] cur_range_s;
    logic [7:0] cur_range_v;
  } result_t;

  typedef struct packed {
    logic [7:0] h;
    logic [7:0] s;
    logic [7:0] v;
    logic [7:0] rh;
    logic [7:0] rs;
    logic [7:0] rv;
  } colour_t;

  localparam colour_t COLOUR_RESET = '{
    h: 8'd90, s: 8'd240, v: 8'd200, rh: 8'd10, rs: 8'd50, rv: 8'd50
  };

  // one step of datapath work per flag
  typedef struct packed {
    logic take;
    logic exec;
    logic mul;
    logic div_step;
    logic avg_write;
    logic grow;
    logic span;
    logic bounds;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] pixel_action;
    logic       inc_first;
    logic       div_last;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/hrcl_datapath.sv
`default_nettype none

module hrcl_datapath (
  input  logic              clk,
  input  logic              rst,
  input  hrcl_pkg::dp_cmd_t cmd,
  output hrcl_pkg::dp_sts_t sts,
  input  hrcl_pkg::pixel_t  pixel,
  output hrcl_pkg::result_t result
);
  import hrcl_pkg::*;

  typedef logic [255:0][7:0] hue_lut_t;

  function automatic hue_lut_t build_hue_lut();
    hue_lut_t lut;
    for (int i = 0; i < 256; i++) begin
      lut[i] = 8'(i % HUE_STEPS);
    end
    return lut;
  endfunction

  localparam hue_lut_t HUE_MOD_LUT = build_hue_lut();

  // x is below twice the hue scale
  function automatic logic [7:0] hue_wrap(input logic [8:0] x);
    logic [7:0] w;
    if (x >= HUE_STEPS_W) begin
      w = 8'(x - HUE_STEPS_W);
    end else begin
      w = x[7:0];
    end
    return w;
  endfunction

  // (a - b) around the hue circle
  function automatic logic [7:0] hue_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    if (a >= b) begin
      d = a - b;
    end else begin
      d = 8'({1'b0, a} + HUE_STEPS_W - {1'b0, b});
    end
    return d;
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] c);
    return (c == CNT_MAX) ? CNT_MAX : c + 8'd1;
  endfunction

  // stretch a linear window just enough to hold p; returns {target, half_range}
  function automatic logic [15:0] grow_chan(input logic [7:0] t, input logic [7:0] r,
                                            input logic [7:0] p);
    logic [8:0]  upper;
    logic [8:0]  p_low;
    logic [7:0]  b;
    logic [8:0]  span;
    logic [15:0] res;
    upper = {1'b0, t} + {1'b0, r};
    p_low = {1'b0, p} + {1'b0, r};
    res   = {t, r};
    if ({1'b0, p} > upper) begin
      b    = (t > r) ? t - r : 8'd0;
      span = {1'b0, p - b} + 9'd1;
      res  = {b + span[8:1], span[8:1]};
    end else if (p_low < {1'b0, t}) begin
      b    = upper[8] ? CHAN_MAX : upper[7:0];
      span = {1'b0, b - p} + 9'd1;
      res  = {p + span[8:1], span[8:1]};
    end
    return res;
  endfunction

  colour_t    colour;
  colour_t    prev_colour;
  logic [7:0] avg_cnt;
  logic [7:0] inc_cnt;
  pixel_t     item;

  logic [7:0] hue_lo, hue_hi, sat_lo, sat_hi, val_lo, val_hi;
  logic [7:0] grow_lo, grow_hi;
  logic       grow_out;

  logic [7:0] rem [3];
  logic [7:0] quo [3];
  logic [2:0] div_cnt;

  logic [7:0]  hm;
  logic [7:0]  hx;
  logic [8:0]  s_sum, v_sum;
  logic [7:0]  win_lo, win_hi, s_hi_c, s_lo_c, v_hi_c, v_lo_c;
  logic        hue_ok, hit;
  logic        outside;
  logic [7:0]  di, dj;
  logic [7:0]  span_c, span_rh, span_h;
  logic [15:0] grow_s, grow_v;
  logic [8:0]  divisor;
  logic [7:0]  tgt_chan [3];
  logic [7:0]  pix_chan [3];
  logic [15:0] dividend [3];
  logic [8:0]  trial [3];

  assign hm = HUE_MOD_LUT[item.pixel_hue];

  // window bounds from the current colour
  always_comb begin
    hx     = (colour.rh > HUE_CAP) ? HUE_CAP : colour.rh;
    win_hi = hue_wrap({1'b0, colour.h} + {1'b0, hx});
    win_lo = hue_diff(colour.h, hx);
    s_sum  = {1'b0, colour.s} + {1'b0, colour.rs};
    v_sum  = {1'b0, colour.v} + {1'b0, colour.rv};
    s_hi_c = s_sum[8] ? CHAN_MAX : s_sum[7:0];
    v_hi_c = v_sum[8] ? CHAN_MAX : v_sum[7:0];
    s_lo_c = (colour.s > colour.rs) ? colour.s - colour.rs : 8'd0;
    v_lo_c = (colour.v > colour.rv) ? colour.v - colour.rv : 8'd0;
  end

  // classify against the registered window, raw pixel hue
  always_comb begin
    if (hue_hi >= hue_lo) begin
      hue_ok = (item.pixel_hue >= hue_lo) && (item.pixel_hue <= hue_hi);
    end else begin
      hue_ok = (item.pixel_hue >= hue_lo) || (item.pixel_hue <= hue_hi);
    end
    hit = hue_ok && (item.pixel_sat >= sat_lo) && (item.pixel_sat <= sat_hi) &&
          (item.pixel_val >= val_lo) && (item.pixel_val <= val_hi);
  end

  // hue growth, first half: which bound moves
  always_comb begin
    if (hue_hi >= hue_lo) begin
      outside = (hm > hue_hi) || (hm < hue_lo);
    end else begin
      outside = (hm > hue_hi) && (hm < hue_lo);
    end
    di = hue_diff(hm, hue_hi);
    dj = hue_diff(hue_lo, hm);
  end

  // hue growth, second half: centre and half-range of the new span
  always_comb begin
    span_c  = hue_diff(grow_hi, grow_lo);
    span_rh = 8'(({1'b0, span_c} + 9'd1) >> 1);
    span_h  = hue_wrap({1'b0, grow_lo} + {1'b0, span_rh});
  end

  assign grow_s = grow_chan(colour.s, colour.rs, item.pixel_sat);
  assign grow_v = grow_chan(colour.v, colour.rv, item.pixel_val);

  // averaging lanes: weighted sum, then restoring division by n + 1
  always_comb begin
    divisor     = {1'b0, avg_cnt} + 9'd1;
    tgt_chan[0] = colour.h;
    tgt_chan[1] = colour.s;
    tgt_chan[2] = colour.v;
    pix_chan[0] = hm;
    pix_chan[1] = item.pixel_sat;
    pix_chan[2] = item.pixel_val;
    for (int k = 0; k < 3; k++) begin
      dividend[k] = (16'(tgt_chan[k]) * 16'(avg_cnt)) + 16'(pix_chan[k]);
      trial[k]    = {rem[k], quo[k][7]};
    end
  end

  assign sts.pixel_action = pixel.action;
  assign sts.inc_first    = (inc_cnt == 8'd0);
  assign sts.div_last     = (div_cnt == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      colour      <= COLOUR_RESET;
      prev_colour <= COLOUR_RESET;
      avg_cnt     <= 8'd0;
      inc_cnt     <= 8'd0;
      div_cnt     <= 3'd0;
    end else begin
      if (cmd.exec) begin
        case (item.action)
          ACT_PICK: begin
            prev_colour <= colour;
            colour.h    <= hm;
            colour.s    <= item.pixel_sat;
            colour.v    <= item.pixel_val;
            avg_cnt     <= 8'd0;
            inc_cnt     <= 8'd0;
          end
          ACT_INCLUDE: begin
            // first include: the window collapses onto the pixel
            prev_colour <= colour;
            colour      <= '{h: hm, s: item.pixel_sat, v: item.pixel_val,
                             rh: 8'd1, rs: 8'd1, rv: 8'd1};
            inc_cnt     <= sat_inc(inc_cnt);
            avg_cnt     <= 8'd0;
          end
          ACT_UNDO: begin
            colour <= prev_colour;
            if (inc_cnt != 8'd0) begin
              inc_cnt <= inc_cnt - 8'd1;
            end
            if (avg_cnt != 8'd0) begin
              avg_cnt <= avg_cnt - 8'd1;
            end
          end
          ACT_LOAD: begin
            colour.h  <= (item.pixel_hue > HUE_MAX) ? HUE_MAX : item.pixel_hue;
            colour.s  <= item.pixel_sat;
            colour.v  <= item.pixel_val;
            colour.rh <= (item.load_range_h > HUE_MAX) ? HUE_MAX : item.load_range_h;
            colour.rs <= item.load_range_s;
            colour.rv <= item.load_range_v;
          end
          default: begin
          end
        endcase
      end
      if (cmd.mul) begin
        prev_colour <= colour;
        div_cnt     <= 3'd0;
      end
      if (cmd.div_step) begin
        div_cnt <= div_cnt + 3'd1;
      end
      if (cmd.avg_write) begin
        colour.h <= quo[0];
        colour.s <= quo[1];
        colour.v <= quo[2];
        avg_cnt  <= sat_inc(avg_cnt);
        inc_cnt  <= 8'd0;
      end
      if (cmd.grow) begin
        prev_colour <= colour;
        colour.s    <= grow_s[15:8];
        colour.rs   <= grow_s[7:0];
        colour.v    <= grow_v[15:8];
        colour.rv   <= grow_v[7:0];
        inc_cnt     <= sat_inc(inc_cnt);
        avg_cnt     <= 8'd0;
      end
      if (cmd.span && grow_out) begin
        colour.h  <= span_h;
        colour.rh <= span_rh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item <= pixel;
    end
    if (cmd.bounds) begin
      hue_lo <= win_lo;
      hue_hi <= win_hi;
      sat_lo <= s_lo_c;
      sat_hi <= s_hi_c;
      val_lo <= v_lo_c;
      val_hi <= v_hi_c;
    end
    if (cmd.grow) begin
      grow_out <= outside;
      grow_lo  <= (di <= dj) ? hue_lo : hm;
      grow_hi  <= (di <= dj) ? hm : hue_hi;
    end
    if (cmd.mul) begin
      for (int k = 0; k < 3; k++) begin
        rem[k] <= dividend[k][15:8];
        quo[k] <= dividend[k][7:0];
      end
    end else if (cmd.div_step) begin
      for (int k = 0; k < 3; k++) begin
        if (trial[k] >= divisor) begin
          rem[k] <= 8'(trial[k] - divisor);
          quo[k] <= {quo[k][6:0], 1'b1};
        end else begin
          rem[k] <= trial[k][7:0];
          quo[k] <= {quo[k][6:0], 1'b0};
        end
      end
    end
    if (cmd.emit) begin
      result <= '{in_range: (item.action == ACT_CLASSIFY) && hit,
                  cur_hue: colour.h, cur_sat: colour.s, cur_val: colour.v,
                  cur_range_h: colour.rh, cur_range_s: colour.rs,
                  cur_range_v: colour.rv};
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/hrcl_ctrl.sv
`default_nettype none

module hrcl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              pixel_valid,
  output logic              pixel_ready,
  output logic              result_valid,
  input  logic              result_ready,
  input  hrcl_pkg::dp_sts_t sts,
  output hrcl_pkg::dp_cmd_t cmd
);
  import hrcl_pkg::*;

  typedef enum logic [9:0] {
    ST_INIT   = 10'b00_0000_0001,
    ST_IDLE   = 10'b00_0000_0010,
    ST_EXEC   = 10'b00_0000_0100,
    ST_MUL    = 10'b00_0000_1000,
    ST_DIV    = 10'b00_0001_0000,
    ST_AVG    = 10'b00_0010_0000,
    ST_GROW   = 10'b00_0100_0000,
    ST_SPAN   = 10'b00_1000_0000,
    ST_BOUNDS = 10'b01_0000_0000,
    ST_DONE   = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  assign pixel_ready = (state == ST_IDLE) && !rst;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_INIT: begin
        cmd.bounds = 1'b1;
        state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (pixel_valid) begin
          cmd.take = 1'b1;
          case (sts.pixel_action)
            ACT_CLASSIFY: state_next = ST_DONE;
            ACT_AVERAGE:  state_next = ST_MUL;
            ACT_INCLUDE:  state_next = sts.inc_first ? ST_EXEC : ST_GROW;
            default:      state_next = ST_EXEC;
          endcase
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_BOUNDS;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_AVG;
        end
      end
      ST_AVG: begin
        cmd.avg_write = 1'b1;
        state_next    = ST_BOUNDS;
      end
      ST_GROW: begin
        cmd.grow   = 1'b1;
        state_next = ST_SPAN;
      end
      ST_SPAN: begin
        cmd.span   = 1'b1;
        state_next = ST_BOUNDS;
      end
      ST_BOUNDS: begin
        cmd.bounds = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!result_valid || result_ready) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/hsv_range_classifier_learner_unit.sv
// HSV colour window classifier with a learned target colour.
// Pixel channel: pixel_valid / pixel_ready, payload pixel (action and HSV
// pixel, plus half-ranges for a load). Result channel: result_valid /
// result_ready, payload result: the mask bit and the colour after the step.
// Every accepted beat gives exactly one result beat.
// Steps per item: classify goes straight to its result; pick, undo, load,
// first include and unused codes execute, refresh the bounds, then emit; an
// include that grows the window grows, spans, refreshes the bounds and emits;
// average multiplies, divides, writes, refreshes the bounds and emits.
// The window bounds live in registers refreshed in the cycle after each colour
// change, so classify is a single compare. Average runs a restoring divider,
// one quotient bit per cycle, three lanes side by side. The result sits in an
// output register; a new beat is taken while it waits. If the receiver stalls,
// the next item runs up to its result and holds there until the register frees;
// pixel_ready stays low meanwhile. Reset restores the default colour (hue 90,
// sat 240, val 200, ranges 10, 50, 50), clears both counts and loads the window
// bounds in its init state before pixel_ready rises.
`default_nettype none

module hsv_range_classifier_learner_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              pixel_valid,
  output logic              pixel_ready,
  input  hrcl_pkg::pixel_t  pixel,
  output logic              result_valid,
  input  logic              result_ready,
  output hrcl_pkg::result_t result
);
  import hrcl_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencing: one step per cycle while not waiting on a pixel or the result port
  hrcl_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // colour state, window, divider lanes and output register
  hrcl_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .pixel  (pixel),
    .result (result)
  );

  // the controller never issues two datapath steps at once
  assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath step in a cycle");

  // a result beat is never overwritten before it is taken
  assert property (@(posedge clk) disable iff (rst)
                   cmd.emit |-> (!result_valid || result_ready))
    else $error("result register overwritten");

  // one item at a time: after an accepted beat the port closes
  assert property (@(posedge clk) disable iff (rst)
                   (pixel_valid && pixel_ready) |=> !pixel_ready)
    else $error("second beat accepted while an item is in flight");

  // the target hue always stays on the hue circle
  assert property (@(posedge clk) disable iff (rst)
                   result_valid |-> ({1'b0, result.cur_hue} < HUE_STEPS_W))
    else $error("target hue off the hue circle");

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import hrcl_pkg::*;

  // codes the block ignores
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  // The slowest beat is an average plus the result stall. The cycle limit is
  // many times the worst correct run of ~1200 beats.
  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_BEATS = 1150;
  localparam int SAT_RUN      = 258;   // long enough to pin a count at 255

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    pixel_valid = 1'b0;
  logic    pixel_ready;
  pixel_t  pixel = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  pixel_t  pending_pixels[$];      // beats still to be offered
  result_t predicted_results[$];   // results owed by the block, oldest first
  int      planned_items = 0;
  int      pixels_accepted = 0;
  int      failures = 0;
  int      cycle_count = 0;
  logic    pixel_taken = 1'b0;     // last rising edge accepted a pixel beat

  // shadow of the block's colour state
  colour_t     colour_now = COLOUR_RESET;
  colour_t     colour_saved = COLOUR_RESET;
  int unsigned avg_count = 0;
  int unsigned inc_count = 0;

  hsv_range_classifier_learner_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Hue window bounds; the half-range is capped so the window never laps.
  function automatic void hue_bounds(input colour_t c, output int lo, output int hi);
    int x;
    x = (c.rh > HUE_CAP) ? int'(HUE_CAP) : int'(c.rh);
    hi = (int'(c.h) + x) % HUE_STEPS;
    lo = (int'(c.h) + HUE_STEPS - x) % HUE_STEPS;
  endfunction

  // Stretch a sat/val window just enough to hold p; the far bound is kept,
  // clamped to 0..255, and the half-range rounds up.
  function automatic void widen_channel(inout logic [7:0] t, inout logic [7:0] r,
                                        input int p);
    int tv, rv, b;
    tv = t;
    rv = r;
    if (p > tv + rv) begin
      b = (tv > rv) ? tv - rv : 0;
      rv = (p - b + 1) / 2;
      r = 8'(rv);
      t = 8'(b + rv);
    end else if (p + rv < tv) begin
      b = (tv + rv > 255) ? 255 : tv + rv;
      rv = (b - p + 1) / 2;
      r = 8'(rv);
      t = 8'(p + rv);
    end
  endfunction

  // Hue outside the window: move the circularly nearer bound onto it.
  function automatic void widen_hue(inout colour_t c, input int p);
    int lo, hi, di, dj, span;
    bit outside;
    hue_bounds(c, lo, hi);
    if (hi >= lo) outside = (p > hi) || (p < lo);
    else outside = (p > hi) && (p < lo);
    if (outside) begin
      di = (p + HUE_STEPS - hi) % HUE_STEPS;
      dj = (lo + HUE_STEPS - p) % HUE_STEPS;
      if (di <= dj) hi = p;
      else lo = p;
      span = (hi + HUE_STEPS - lo) % HUE_STEPS;
      c.rh = 8'((span + 1) / 2);
      c.h = 8'((lo + (span + 1) / 2) % HUE_STEPS);
    end
  endfunction

  // Apply one pixel beat to the shadow state and return the result it owes.
  function automatic result_t step_colour(pixel_t p);
    result_t    r;
    int         lo, hi, hm, n, smin, smax, vmin, vmax;
    logic [7:0] t, w;
    bit         hit, hue_ok;
    hit = 1'b0;
    hm = int'(p.pixel_hue) % HUE_STEPS;
    case (p.action)
      ACT_CLASSIFY: begin
        // classify uses the raw hue; codes past the scale can only match a
        // window that wraps through zero
        hue_bounds(colour_now, lo, hi);
        smax = int'(colour_now.s) + int'(colour_now.rs);
        if (smax > 255) smax = 255;
        smin = (colour_now.s > colour_now.rs) ? int'(colour_now.s) - int'(colour_now.rs) : 0;
        vmax = int'(colour_now.v) + int'(colour_now.rv);
        if (vmax > 255) vmax = 255;
        vmin = (colour_now.v > colour_now.rv) ? int'(colour_now.v) - int'(colour_now.rv) : 0;
        if (hi >= lo) hue_ok = (p.pixel_hue >= lo) && (p.pixel_hue <= hi);
        else hue_ok = (p.pixel_hue >= lo) || (p.pixel_hue <= hi);
        hit = hue_ok && p.pixel_sat >= smin && p.pixel_sat <= smax &&
              p.pixel_val >= vmin && p.pixel_val <= vmax;
      end
      ACT_PICK: begin
        colour_saved = colour_now;
        avg_count = 0;
        inc_count = 0;
        colour_now.h = 8'(hm);
        colour_now.s = p.pixel_sat;
        colour_now.v = p.pixel_val;
      end
      ACT_AVERAGE: begin
        n = avg_count;
        colour_saved = colour_now;
        colour_now.h = 8'((int'(colour_now.h) * n + hm) / (n + 1));
        colour_now.s = 8'((int'(colour_now.s) * n + int'(p.pixel_sat)) / (n + 1));
        colour_now.v = 8'((int'(colour_now.v) * n + int'(p.pixel_val)) / (n + 1));
        if (avg_count < CNT_MAX) avg_count++;
        inc_count = 0;
      end
      ACT_INCLUDE: begin
        colour_saved = colour_now;
        if (inc_count == 0) begin
          colour_now = '{h: 8'(hm), s: p.pixel_sat, v: p.pixel_val,
                         rh: 8'd1, rs: 8'd1, rv: 8'd1};
        end else begin
          widen_hue(colour_now, hm);
          t = colour_now.s;
          w = colour_now.rs;
          widen_channel(t, w, p.pixel_sat);
          colour_now.s = t;
          colour_now.rs = w;
          t = colour_now.v;
          w = colour_now.rv;
          widen_channel(t, w, p.pixel_val);
          colour_now.v = t;
          colour_now.rv = w;
        end
        if (inc_count < CNT_MAX) inc_count++;
        avg_count = 0;
      end
      ACT_UNDO: begin
        colour_now = colour_saved;   // the saved copy stays
        if (inc_count != 0) inc_count--;
        if (avg_count != 0) avg_count--;
      end
      ACT_LOAD: begin
        colour_now.h = (p.pixel_hue > HUE_MAX) ? HUE_MAX : p.pixel_hue;
        colour_now.s = p.pixel_sat;
        colour_now.v = p.pixel_val;
        colour_now.rh = (p.load_range_h > HUE_MAX) ? HUE_MAX : p.load_range_h;
        colour_now.rs = p.load_range_s;
        colour_now.rv = p.load_range_v;
      end
      default: ;
    endcase
    r.in_range = hit;
    r.cur_hue = colour_now.h;
    r.cur_sat = colour_now.s;
    r.cur_val = colour_now.v;
    r.cur_range_h = colour_now.rh;
    r.cur_range_s = colour_now.rs;
    r.cur_range_v = colour_now.rv;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic void queue_pixel(logic [2:0] act, int h, int s, int v,
                                      int rh = 0, int rs = 0, int rv = 0);
    pixel_t p;
    p.action = act;
    p.pixel_hue = 8'(h);
    p.pixel_sat = 8'(s);
    p.pixel_val = 8'(v);
    p.load_range_h = 8'(rh);
    p.load_range_s = 8'(rs);
    p.load_range_v = 8'(rv);
    pending_pixels.insert(pending_pixels.size(), p);
  endfunction

  function automatic int hue_near(int centre, int spread);
    return (centre + HUE_STEPS + int'($urandom_range(2 * spread)) - spread) % HUE_STEPS;
  endfunction

  function automatic int chan_near(int centre, int spread);
    int c;
    c = centre + int'($urandom_range(2 * spread)) - spread;
    return (c < 0) ? 0 : (c > 255) ? 255 : c;
  endfunction

  // A colour set up by load or pick, then mostly classify around it with
  // some learning and undo mixed in.
  function automatic void queue_learning_sequence();
    int th, ts, tv, rh, rs, rv, hs, r;
    th = $urandom_range(HUE_STEPS - 1);
    ts = $urandom_range(255);
    tv = $urandom_range(255);
    rh = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(30);
    rs = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(60);
    rv = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(60);
    if ($urandom_range(1)) begin
      queue_pixel(ACT_LOAD, th, ts, tv, rh, rs, rv);
    end else begin
      queue_pixel(ACT_PICK, th, ts, tv);
      rh = 20;
      rs = 40;
      rv = 40;
    end
    hs = ((rh > HUE_CAP) ? int'(HUE_CAP) : rh) + 4;
    repeat ($urandom_range(16, 4)) begin
      r = $urandom_range(99);
      if (r < 60)
        queue_pixel(ACT_CLASSIFY, hue_near(th, hs), chan_near(ts, rs + 4),
                    chan_near(tv, rv + 4));
      else if (r < 72)
        queue_pixel(ACT_AVERAGE, hue_near(th, 8), chan_near(ts, 16), chan_near(tv, 16));
      else if (r < 86)
        queue_pixel(ACT_INCLUDE, hue_near(th, 25), chan_near(ts, 40), chan_near(tv, 40));
      else if (r < 94)
        queue_pixel(ACT_UNDO, 0, 0, 0);
      else
        queue_pixel(ACT_CLASSIFY, $urandom_range(255, HUE_STEPS), ts, tv);
    end
  endfunction

  // idle odds follow the share of beats already taken
  function automatic int sender_idle_pct();
    if (pixels_accepted * 3 < planned_items) return 9;
    if (pixels_accepted * 3 < planned_items * 2) return 81;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (pixels_accepted * 3 < planned_items) return 81;
    if (pixels_accepted * 3 < planned_items * 2) return 9;
    return 0;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      failures++;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Driver: inputs move on the falling edge. A held beat keeps its payload
  // until the edge that accepts it.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst && (!pixel_valid || pixel_taken)) begin
      if (pending_pixels.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
        pixel <= pending_pixels.pop_front();
        pixel_valid <= 1'b1;
      end else begin
        pixel_valid <= 1'b0;
      end
    end
    result_ready <= !rst && ($urandom_range(99) >= receiver_idle_pct());
  end

  // Each accepted pixel beat steps the shadow state at once.
  always @(posedge clk) begin
    pixel_taken <= pixel_valid && pixel_ready;
    if (pixel_valid && pixel_ready) begin
      predicted_results.insert(predicted_results.size(), step_colour(pixel));
      pixels_accepted++;
    end
  end

  // Monitor: every result beat against the oldest prediction.
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (result_valid && result_ready) begin
      if (predicted_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %p", $time, result);
        failures++;
      end else begin
        want = predicted_results.pop_front();
        check_field("in_range", 8'(want.in_range), 8'(result.in_range));
        check_field("cur_hue", want.cur_hue, result.cur_hue);
        check_field("cur_sat", want.cur_sat, result.cur_sat);
        check_field("cur_val", want.cur_val, result.cur_val);
        check_field("cur_range_h", want.cur_range_h, result.cur_range_h);
        check_field("cur_range_s", want.cur_range_s, result.cur_range_s);
        check_field("cur_range_v", want.cur_range_v, result.cur_range_v);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int centre_h, centre_s, centre_v, directed_items, r;

    // Directed: default window edges, clamping, raw hue past the scale.
    queue_pixel(ACT_CLASSIFY, 90, 240, 200);   // dead centre
    queue_pixel(ACT_CLASSIFY, 80, 190, 150);   // lower bounds, inclusive
    queue_pixel(ACT_CLASSIFY, 100, 255, 250);  // upper bounds, sat clamps at 255
    queue_pixel(ACT_CLASSIFY, 101, 240, 200);  // just past hue
    queue_pixel(ACT_CLASSIFY, 90, 189, 200);   // just under sat
    queue_pixel(ACT_CLASSIFY, 255, 240, 200);  // raw hue, never reduced
    // load saturates hue and hue range; capped window wraps
    queue_pixel(ACT_LOAD, 255, 0, 255, 255, 0, 255);
    queue_pixel(ACT_CLASSIFY, 0, 0, 0);
    queue_pixel(ACT_CLASSIFY, 89, 1, 128);
    // window straddling zero
    queue_pixel(ACT_LOAD, 5, 128, 128, 10, 20, 20);
    queue_pixel(ACT_CLASSIFY, 178, 128, 128);
    queue_pixel(ACT_CLASSIFY, 16, 128, 128);
    queue_pixel(ACT_CLASSIFY, 174, 128, 128);
    // learning with hues past the scale, then undo twice
    queue_pixel(ACT_PICK, 200, 255, 0);
    queue_pixel(ACT_AVERAGE, 230, 0, 255);
    queue_pixel(ACT_AVERAGE, 179, 255, 0);
    queue_pixel(ACT_INCLUDE, 250, 10, 240);
    queue_pixel(ACT_INCLUDE, 60, 0, 255);
    queue_pixel(ACT_INCLUDE, 100, 255, 0);
    queue_pixel(ACT_UNDO, 0, 0, 0);
    queue_pixel(ACT_UNDO, 0, 0, 0);
    // spare codes must leave everything alone
    queue_pixel(ACT_SPARE_6, 255, 255, 255, 255, 255, 255);
    queue_pixel(ACT_SPARE_7, 255, 255, 255, 255, 255, 255);
    queue_pixel(ACT_LOAD, 0, 0, 0, 0, 0, 0);
    queue_pixel(ACT_CLASSIFY, 0, 0, 0);
    directed_items = pending_pixels.size();

    // Averaging count driven into saturation, classify sprinkled through.
    queue_pixel(ACT_PICK, $urandom_range(HUE_STEPS - 1), $urandom_range(255),
                $urandom_range(255));
    repeat (SAT_RUN) begin
      queue_pixel(ACT_AVERAGE, $urandom_range(255), $urandom_range(255), $urandom_range(255));
      if ($urandom_range(3) == 0)
        queue_pixel(ACT_CLASSIFY, $urandom_range(HUE_STEPS - 1), $urandom_range(255),
                    $urandom_range(255));
    end
    queue_pixel(ACT_UNDO, 0, 0, 0);
    queue_pixel(ACT_AVERAGE, $urandom_range(255), $urandom_range(255), $urandom_range(255));

    // Same for the include count; the window creeps out around a centre.
    centre_h = $urandom_range(HUE_STEPS - 1);
    centre_s = $urandom_range(255);
    centre_v = $urandom_range(255);
    repeat (SAT_RUN) begin
      queue_pixel(ACT_INCLUDE, hue_near(centre_h, 60), chan_near(centre_s, 70),
                  chan_near(centre_v, 70));
      if ($urandom_range(3) == 0)
        queue_pixel(ACT_CLASSIFY, $urandom_range(255), $urandom_range(255),
                    $urandom_range(255));
    end
    queue_pixel(ACT_UNDO, 0, 0, 0);
    queue_pixel(ACT_INCLUDE, $urandom_range(255), $urandom_range(255), $urandom_range(255));

    // Mostly well-formed sequences, some classify bursts, some noise.
    while (pending_pixels.size() < directed_items + RANDOM_BEATS) begin
      r = $urandom_range(9);
      if (r < 6) begin
        queue_learning_sequence();
      end else if (r < 8) begin
        repeat ($urandom_range(20, 5))
          queue_pixel(ACT_CLASSIFY, $urandom_range(HUE_STEPS - 1), $urandom_range(255),
                      $urandom_range(255));
      end else begin
        repeat ($urandom_range(8, 1))
          queue_pixel(3'($urandom_range(7)), $urandom_range(255), $urandom_range(255),
                      $urandom_range(255), $urandom_range(255), $urandom_range(255),
                      $urandom_range(255));
      end
    end
    planned_items = pending_pixels.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_pixels.size() > 0 || pixel_valid) @(posedge clk);
    while (predicted_results.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);   // room for any stray late beat
    if (failures == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
